@@ rtl/core/hdp_pkg.sv @@
`timescale 1ns / 1ps

package hdp_pkg;

  // Density format: unsigned, DENSITY_BITS fraction bits
  localparam int DENSITY_BITS     = 16;
  localparam int TANH_TABLE_DEPTH = 256;

  // Register port
  localparam int BETA_W      = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SHARPNESS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = CFG_INDEX_W'(1);

  localparam logic [BETA_W-1:0]       SHARPNESS_RESET = BETA_W'(256);
  localparam logic [DENSITY_BITS-1:0] THRESHOLD_RESET = DENSITY_BITS'(1 << (DENSITY_BITS - 1));

  // tanh argument has 8 + DENSITY_BITS fraction bits; tanh values are Q1.16
  localparam int ARG_FRAC = 8 + DENSITY_BITS;
  localparam int TANH_W   = 17;
  localparam logic [TANH_W-1:0] TANH_ONE = TANH_W'(65536);

  // Result selection codes
  localparam logic [1:0] RES_DIV  = 2'd0;
  localparam logic [1:0] RES_PASS = 2'd1;
  localparam logic [1:0] RES_ZERO = 2'd2;
  localparam logic [1:0] RES_SAT  = 2'd3;

  // Table step 16/DEPTH in Q0.31
  localparam logic [63:0] TAB_STEP = (64'd16 << 31) / 64'(TANH_TABLE_DEPTH);

  typedef logic [TANH_TABLE_DEPTH:0][TANH_W-1:0] tanh_tab_t;

  // Unsigned 64-bit quotient by shift and subtract, used at elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh table over [0, 8], TANH_TABLE_DEPTH+1 points, evaluated at elaboration.
  // E(i) = exp(-16 i / DEPTH) in Q0.31 via a truncated Taylor series for the step.
  function automatic tanh_tab_t build_tanh_table();
    logic [63:0]        q31;
    logic [63:0]        h;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    logic [63:0]        e;
    tanh_tab_t          tab;
    q31  = 64'd1 << 31;
    h    = TAB_STEP;
    term = q31;
    sum  = $signed(q31);
    tab  = '0;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * h) >> 31, 64'(k));
      if ((k & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    q = $unsigned(sum);
    e = q31;
    for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      tab[i] = TANH_W'(udiv64(((q31 - e) << 16) + ((q31 + e) >> 1), q31 + e));
      e = (e * q + (64'd1 << 30)) >> 31;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_table();

endpackage

@@ rtl/core/heaviside_density_projection_core.sv @@
`timescale 1ns / 1ps

// Smoothed Heaviside (tanh) density projection. Each item carries one filtered
// density x (unsigned Q0.16) and yields (tanh(b*e) + tanh(b*(x-e))) /
// (tanh(b*e) + tanh(b*(1-e))), rounded and saturated to 0..65535, where b is the
// sharpness register (Q8.8) and e the threshold register (Q0.16). tanh comes
// from a 257-point constant table with linear interpolation. The block takes
// one item per cycle unless backpressure has filled the pipeline. Each item
// passes six stages of multiply, table lookup, interpolation and divider setup,
// then an 18-stage restoring divider producing one quotient bit per stage, then
// the output register. Every stage holds its item under backpressure, so empty
// stages keep filling while a result waits at the output. A zero denominator
// passes x through unchanged. Registers take effect for items accepted after
// the write; write them only while the pipeline is empty.
module heaviside_density_projection_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [hdp_pkg::DENSITY_BITS-1:0]      filtered_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [hdp_pkg::DENSITY_BITS-1:0]      projected_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hdp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [hdp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int DB      = hdp_pkg::DENSITY_BITS;
  localparam int DEPTH   = hdp_pkg::TANH_TABLE_DEPTH;
  localparam int TW      = hdp_pkg::TANH_W;
  localparam int AF      = hdp_pkg::ARG_FRAC;
  localparam int DIFF_W  = DB + 1;
  localparam int MW      = hdp_pkg::BETA_W + DIFF_W;
  localparam int IW      = $clog2(DEPTH + 1);
  localparam int POS_W   = MW + IW;
  localparam int SHIFT   = AF + 3;
  localparam int PROD_W  = TW + 16;
  localparam int NUM_W   = TW + 2;
  localparam int DEN_W   = TW + 1;
  localparam int NW      = TW + 2 + DB;
  localparam int QB      = DB + 2;
  localparam int LANES   = 3;
  localparam int DIV0    = 6;
  localparam int NST     = DIV0 + QB + 1;
  localparam logic [DB-1:0] DMASK = {DB{1'b1}};

  // lanes: 0 = b*e, 1 = b*|x-e|, 2 = b*(1-e)

  // Configuration registers
  logic [hdp_pkg::BETA_W-1:0] sharpness;
  logic [DB-1:0]              threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sharpness <= hdp_pkg::SHARPNESS_RESET;
      threshold <= hdp_pkg::THRESHOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hdp_pkg::REG_SHARPNESS: sharpness <= cfg_data;
        hdp_pkg::REG_THRESHOLD: threshold <= DB'(cfg_data);
        default: ;
      endcase
    end
  end

  // Per-stage flow control: a stage loads when empty or when its item moves on
  logic [NST-1:0] vld;
  logic [NST:0]   load;

  always_comb begin
    load[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (load[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // Stage 1: signed difference and the three argument products
  logic [DB-1:0]     s1_x;
  logic              s1_neg;
  logic [MW-1:0]     s1_m [LANES];
  logic [DIFF_W-1:0] opnd [LANES];
  logic              in_neg;

  always_comb begin
    in_neg  = filtered_value < threshold;
    opnd[0] = DIFF_W'(threshold);
    opnd[1] = in_neg ? DIFF_W'(threshold - filtered_value)
                     : DIFF_W'(filtered_value - threshold);
    opnd[2] = DIFF_W'(1 << DB) - DIFF_W'(threshold);
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_x   <= filtered_value;
      s1_neg <= in_neg;
      for (int l = 0; l < LANES; l++) begin
        s1_m[l] <= MW'(sharpness) * MW'(opnd[l]);
      end
    end
  end

  // Stage 2: table position, saturation test and table reads
  logic [DB-1:0]     s2_x;
  logic              s2_neg;
  logic              s2_sat  [LANES];
  logic [TW-1:0]     s2_t0   [LANES];
  logic [TW-1:0]     s2_t1   [LANES];
  logic [15:0]       s2_frac [LANES];
  logic [POS_W-1:0]  pos     [LANES];
  logic [IW-1:0]     idx     [LANES];
  logic [IW-1:0]     idx1    [LANES];
  logic              pos_sat [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pos[l]     = POS_W'(s1_m[l]) * POS_W'(DEPTH);
      pos_sat[l] = (pos[l] >> SHIFT) >= POS_W'(DEPTH);
      idx[l]     = pos[l][SHIFT +: IW];
      idx1[l]    = idx[l] + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_x   <= s1_x;
      s2_neg <= s1_neg;
      for (int l = 0; l < LANES; l++) begin
        s2_sat[l]  <= pos_sat[l];
        s2_t0[l]   <= pos_sat[l] ? hdp_pkg::TANH_ONE : hdp_pkg::TANH_TAB[idx[l]];
        s2_t1[l]   <= pos_sat[l] ? hdp_pkg::TANH_ONE : hdp_pkg::TANH_TAB[idx1[l]];
        s2_frac[l] <= pos[l][SHIFT-1 -: 16];
      end
    end
  end

  // Stage 3: interpolation product
  logic [DB-1:0]     s3_x;
  logic              s3_neg;
  logic              s3_sat  [LANES];
  logic [TW-1:0]     s3_t0   [LANES];
  logic [PROD_W-1:0] s3_prod [LANES];
  logic [TW-1:0]     step    [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      step[l] = (s2_t1[l] >= s2_t0[l]) ? s2_t1[l] - s2_t0[l] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_x   <= s2_x;
      s3_neg <= s2_neg;
      for (int l = 0; l < LANES; l++) begin
        s3_sat[l]  <= s2_sat[l];
        s3_t0[l]   <= s2_t0[l];
        s3_prod[l] <= PROD_W'(step[l]) * PROD_W'(s2_frac[l]);
      end
    end
  end

  // Stage 4: rounded interpolation
  logic [DB-1:0] s4_x;
  logic          s4_neg;
  logic [TW-1:0] s4_th [LANES];

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s4_x   <= s3_x;
      s4_neg <= s3_neg;
      for (int l = 0; l < LANES; l++) begin
        s4_th[l] <= s3_sat[l] ? hdp_pkg::TANH_ONE
                              : s3_t0[l] + TW'((s3_prod[l] + PROD_W'(32768)) >> 16);
      end
    end
  end

  // Stage 5: numerator and denominator
  logic [DB-1:0]           s5_x;
  logic signed [NUM_W-1:0] s5_num;
  logic [DEN_W-1:0]        s5_den;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s5_x   <= s4_x;
      s5_num <= s4_neg ? $signed(NUM_W'(s4_th[0])) - $signed(NUM_W'(s4_th[1]))
                       : $signed(NUM_W'(s4_th[0])) + $signed(NUM_W'(s4_th[1]));
      s5_den <= DEN_W'(s4_th[0]) + DEN_W'(s4_th[2]);
    end
  end

  // Stage 6: dividend with rounding, special cases, divider seed
  logic [DB-1:0]    s6_x;
  logic [1:0]       s6_kind;
  logic [DEN_W-1:0] s6_rem;
  logic [QB-1:0]    s6_nlow;
  logic [DEN_W-1:0] s6_den;
  logic [NW-1:0]    dividend;
  logic [TW-1:0]    div_top;
  logic [1:0]       kind;

  always_comb begin
    dividend = (NW'(unsigned'(s5_num)) << DB) + NW'(s5_den >> 1);
    div_top  = dividend[NW-1:QB];
    if (s5_den == '0) begin
      kind = hdp_pkg::RES_PASS;
    end else if (s5_num <= 0) begin
      kind = hdp_pkg::RES_ZERO;
    end else if (DEN_W'(div_top) >= s5_den) begin
      kind = hdp_pkg::RES_SAT;
    end else begin
      kind = hdp_pkg::RES_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s6_x    <= s5_x;
      s6_kind <= kind;
      s6_rem  <= DEN_W'(div_top);
      s6_nlow <= dividend[QB-1:0];
      s6_den  <= s5_den;
    end
  end

  // Divider: one restoring step per stage
  logic [DB-1:0]    dv_x    [QB];
  logic [1:0]       dv_kind [QB];
  logic [DEN_W-1:0] dv_rem  [QB];
  logic [QB-1:0]    dv_nlow [QB];
  logic [DEN_W-1:0] dv_den  [QB];
  logic [QB-1:0]    dv_q    [QB];

  logic [DB-1:0]    src_x    [QB];
  logic [1:0]       src_kind [QB];
  logic [DEN_W-1:0] src_rem  [QB];
  logic [QB-1:0]    src_nlow [QB];
  logic [DEN_W-1:0] src_den  [QB];
  logic [QB-1:0]    src_q    [QB];
  logic [DEN_W:0]   cand     [QB];
  logic             qbit     [QB];
  logic [DEN_W-1:0] rem_next [QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        src_x[k]    = s6_x;
        src_kind[k] = s6_kind;
        src_rem[k]  = s6_rem;
        src_nlow[k] = s6_nlow;
        src_den[k]  = s6_den;
        src_q[k]    = '0;
      end else begin
        src_x[k]    = dv_x[(k == 0) ? 0 : k - 1];
        src_kind[k] = dv_kind[(k == 0) ? 0 : k - 1];
        src_rem[k]  = dv_rem[(k == 0) ? 0 : k - 1];
        src_nlow[k] = dv_nlow[(k == 0) ? 0 : k - 1];
        src_den[k]  = dv_den[(k == 0) ? 0 : k - 1];
        src_q[k]    = dv_q[(k == 0) ? 0 : k - 1];
      end
      cand[k] = {src_rem[k], src_nlow[k][QB-1]};
      qbit[k] = cand[k] >= {1'b0, src_den[k]};
      rem_next[k] = qbit[k] ? DEN_W'(cand[k] - {1'b0, src_den[k]}) : DEN_W'(cand[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QB; k++) begin
      if (load[DIV0 + k]) begin
        dv_x[k]    <= src_x[k];
        dv_kind[k] <= src_kind[k];
        dv_rem[k]  <= rem_next[k];
        dv_nlow[k] <= src_nlow[k] << 1;
        dv_den[k]  <= src_den[k];
        dv_q[k]    <= {src_q[k][QB-2:0], qbit[k]};
      end
    end
  end

  // Output register: result selection and saturation
  logic [DB-1:0] result;

  always_comb begin
    case (dv_kind[QB-1])
      hdp_pkg::RES_PASS: result = dv_x[QB-1];
      hdp_pkg::RES_ZERO: result = '0;
      hdp_pkg::RES_SAT:  result = DMASK;
      default: result = (dv_q[QB-1] > QB'(DMASK)) ? DMASK : dv_q[QB-1][DB-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[NST-1]) begin
      projected_value <= result;
    end
  end

endmodule

@@ tb/sv/heaviside_density_projection_core_tb.sv @@
`timescale 1ns / 1ps

module heaviside_density_projection_core_tb;
  import hdp_pkg::*;

  localparam int DW          = DENSITY_BITS;
  localparam int ARG_BITS    = 8 + DENSITY_BITS;   // fraction bits of a tanh argument
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  localparam logic [63:0] FULL_SCALE = 64'd1 << DW;
  localparam logic [63:0] DMASK      = FULL_SCALE - 64'd1;
  localparam logic [63:0] Q31_ONE    = 64'd1 << 31;

  // Indexes past the register list: writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = CFG_INDEX_W'(3);

  typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [DW-1:0] projected_value;
  } projection_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [DW-1:0]          filtered_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DW-1:0]          projected_value;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor state
  logic [63:0]   tanh_curve [0:TANH_TABLE_DEPTH];
  logic [15:0]   sharpness_q = SHARPNESS_RESET;
  logic [DW-1:0] threshold_q = THRESHOLD_RESET;
  projection_t   pending_projections[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // Sender and receiver pacing
  int  tx_burst_left = 0;
  bit  tx_idle = 1'b1;
  bit  tx_steady = 1'b0;
  logic hold_req = 1'b0;
  int  hold_left = 0;
  rx_mode_e rx_mode = RX_ALWAYS;
  int  rx_mode_left = 0;
  int unsigned rx_phase = 0;

  heaviside_density_projection_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .filtered_value  (filtered_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .projected_value (projected_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // tanh over [0, 8]: exp(-16/DEPTH) from a truncated Taylor series, then
  // E(i) by repeated rounded products and tanh = (1-E)/(1+E) in Q1.16
  function automatic void build_tanh_curve();
    logic [63:0]        h;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        step;
    logic [63:0]        e;
    h    = (64'd16 << 31) / 64'(TANH_TABLE_DEPTH);
    term = Q31_ONE;
    sum  = $signed(Q31_ONE);
    for (int k = 1; k <= 20; k++) begin
      term = ((term * h) >> 31) / 64'(k);
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    step = $unsigned(sum);
    e = Q31_ONE;
    for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      tanh_curve[i] = (((Q31_ONE - e) << 16) + (Q31_ONE + e) / 64'd2) / (Q31_ONE + e);
      e = (e * step + (64'd1 << 30)) >> 31;
    end
  endfunction

  // tanh of a non-negative argument with ARG_BITS fraction bits, Q1.16
  function automatic logic [63:0] tanh_of(logic [63:0] mag);
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] t0;
    logic [63:0] t1;
    if (mag >= (64'd8 << ARG_BITS)) begin
      return 64'(TANH_ONE);
    end
    pos = mag * 64'(TANH_TABLE_DEPTH);
    idx = pos >> (ARG_BITS + 3);
    if (idx >= 64'(TANH_TABLE_DEPTH)) begin
      return 64'(TANH_ONE);
    end
    frac = (pos & ((64'd1 << (ARG_BITS + 3)) - 64'd1)) >> (ARG_BITS + 3 - 16);
    t0 = tanh_curve[idx];
    t1 = tanh_curve[idx + 1];
    if (t1 < t0) begin
      t1 = t0;
    end
    return t0 + (((t1 - t0) * frac + 64'd32768) >> 16);
  endfunction

  // Expected projection of one density under the current registers
  function automatic projection_t project_density(logic [DW-1:0] x);
    logic [63:0]        beta;
    logic [63:0]        eta;
    logic [63:0]        xv;
    logic [63:0]        te;
    logic [63:0]        den;
    logic [63:0]        r;
    logic signed [63:0] num;
    projection_t        res;
    beta = 64'(sharpness_q);
    eta  = 64'(threshold_q);
    xv   = 64'(x);
    te   = tanh_of(beta * eta);
    if (xv >= eta) begin
      num = $signed(te + tanh_of(beta * (xv - eta)));
    end else begin
      num = $signed(te) - $signed(tanh_of(beta * (eta - xv)));
    end
    den = te + tanh_of(beta * (FULL_SCALE - eta));
    if (den == 0) begin
      r = xv;            // flat projection passes the density through
    end else if (num <= 0) begin
      r = 0;
    end else begin
      r = (($unsigned(num) << DW) + den / 64'd2) / den;
      if (r > DMASK) begin
        r = DMASK;
      end
    end
    res.projected_value = r[DW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  // Register tracking, result checking and prediction, all at the edge
  always @(posedge clk) begin
    projection_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (rst) begin
      sharpness_q = SHARPNESS_RESET;
      threshold_q = THRESHOLD_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHARPNESS: sharpness_q = cfg_data;
          REG_THRESHOLD: threshold_q = cfg_data[DW-1:0];
          default: ;
        endcase
      end
      if (out_valid !== 1'b0 && out_ready) begin
        if (pending_projections.size() == 0) begin
          report_mismatch($sformatf("unexpected item, projected_value=%0h", projected_value));
        end else begin
          want = pending_projections.pop_front();
          if (projected_value !== want.projected_value) begin
            report_mismatch($sformatf("projected_value got %0h want %0h",
                                      projected_value, want.projected_value));
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_projections.push_back(project_density(filtered_value));
      end
    end
  end

  // Receiver: changing stall patterns, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      rx_phase++;
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(20, 300);
        end
        rx_mode_left--;
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
          default:   out_ready <= ((rx_phase % 9) < 5);
        endcase
      end
    end
  end

  // Offer one density and wait for it to be taken; bursts with gaps
  task automatic send_density(input logic [DW-1:0] x);
    int gap;
    if (tx_idle || (!tx_steady && tx_burst_left == 0)) begin
      if (!tx_idle) begin
        in_valid <= 1'b0;
      end
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      tx_burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
    end
    tx_idle = 1'b0;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
    end
    in_valid       <= 1'b1;
    filtered_value <= x;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic stop_input();
    if (!tx_idle) begin
      in_valid <= 1'b0;
    end
    tx_idle = 1'b1;
    tx_burst_left = 0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_projections.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // Registers change only with the pipeline empty
  task automatic set_registers(input logic [15:0] beta, input logic [DW-1:0] eta);
    stop_input();
    wait_drained();
    write_register(REG_SHARPNESS, beta);
    write_register(REG_THRESHOLD, eta);
    cfg_valid <= 1'b0;
  endtask

  // Random density: uniform, near the threshold, or at the ends
  function automatic logic [DW-1:0] pick_density();
    int d;
    case ($urandom_range(0, 5))
      0, 1: return DW'($urandom);
      2: begin
        d = int'(threshold_q) + $urandom_range(0, 4096) - 2048;
        if (d < 0) d = 0;
        if (d > int'(DMASK)) d = int'(DMASK);
        return DW'(d);
      end
      3: return DW'($urandom_range(0, 255));
      4: return DW'(DMASK - 64'($urandom_range(0, 255)));
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return DW'(DMASK);
          default: return threshold_q;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_sharpness();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 2))
          0: return 16'd0;
          1: return 16'd1;
          default: return 16'hFFFF;
        endcase
      end
      1: return 16'($urandom_range(1, 255));
      2: return 16'($urandom_range(256, 4095));
      3: return 16'($urandom_range(4096, 16383));
      default: return 16'($urandom);
    endcase
  endfunction

  // Reset registers: beta 1.0, eta 0.5
  task automatic test_reset_defaults();
    send_density('0);
    send_density(DW'(1));
    send_density(DW'(16'h7FFF));
    send_density(DW'(16'h8000));
    send_density(DW'(16'h8001));
    send_density(DW'(16'hFFFE));
    send_density(DW'(16'hFFFF));
    send_density(DW'(16'h5555));
  endtask

  // Zero sharpness: zero denominator, density passes through
  task automatic test_zero_sharpness();
    set_registers(16'd0, DW'(16'd12345));
    send_density('0);
    send_density(DW'(16'hAAAA));
    send_density(DW'(16'h3039));
    send_density(DW'(16'hFFFF));
  endtask

  // Steepest projection: step at eta, saturation above full scale
  task automatic test_steep_projection();
    set_registers(16'hFFFF, DW'(16'h8000));
    send_density(DW'(16'h7FFF));
    send_density(DW'(16'h8000));
    send_density(DW'(16'h8001));
    send_density('0);
    send_density(DW'(16'hFFFF));
  endtask

  // Threshold at either end of its range
  task automatic test_threshold_edges();
    set_registers(16'd1, '0);
    send_density('0);
    send_density(DW'(16'h0001));
    send_density(DW'(16'hFFFF));
    set_registers(16'd2560, DW'(16'hFFFF));
    send_density('0);
    send_density(DW'(16'hFFFE));
    send_density(DW'(16'hFFFF));
  endtask

  // Writes beyond the register list leave the registers alone
  task automatic test_spare_registers();
    set_registers(16'd1024, DW'(16'h4000));
    @(posedge clk);
    write_register(REG_SPARE_LO, 16'hFFFF);
    write_register(REG_SPARE_HI, 16'h0000);
    write_register(REG_SPARE_HI, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_density(DW'(16'h3000));
    send_density(DW'(16'h4000));
    send_density(DW'(16'h6000));
  endtask

  // Receiver holds off while the sender keeps pushing: pipeline fills
  task automatic test_backpressure_fill();
    set_registers(16'd2048, DW'(16'h6000));
    tx_steady = 1'b1;
    hold_req <= 1'b1;
    send_density(pick_density());
    hold_req <= 1'b0;
    for (int i = 0; i < 79; i++) begin
      send_density(pick_density());
    end
    tx_steady = 1'b0;
  endtask

  // Sender goes quiet until everything has come back, then resumes
  task automatic test_pause_until_drained();
    for (int i = 0; i < 40; i++) begin
      send_density(pick_density());
    end
    stop_input();
    wait_drained();
    for (int i = 0; i < 40; i++) begin
      send_density(pick_density());
    end
  endtask

  // Random densities over a series of register settings
  task automatic test_random_sweep();
    logic [15:0]   beta;
    logic [DW-1:0] eta;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          beta = 16'hFFFF;
          eta  = DW'($urandom);
        end
        1: begin
          beta = 16'd1;
          eta  = DW'($urandom);
        end
        default: begin
          beta = pick_sharpness();
          case ($urandom_range(0, 4))
            0: eta = '0;
            1: eta = DW'(DMASK);
            default: eta = DW'($urandom);
          endcase
        end
      endcase
      set_registers(beta, eta);
      for (int i = 0; i < 170; i++) begin
        send_density(pick_density());
      end
    end
  endtask

  initial begin
    build_tanh_curve();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_sharpness();
    test_steep_projection();
    test_threshold_edges();
    test_spare_registers();
    test_backpressure_fill();
    test_pause_until_drained();
    test_random_sweep();

    // Drain, then watch for stray results
    stop_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
